FILE: sv/stp_pkg.sv
// shared types, codes and constants of the stepper angle move sequencer
// used by stp_in_stage, stp_core and stepper_angle_move_sequencer; no dependencies
package stp_pkg;

   localparam int StepsPerRevDef = 2048;
   localparam int DegPerRev      = 360;
   localparam int AngleMax       = 360;

   // floor(w / 45) == (w * Div45Mul) >> Div45Shift for every w below 2**15
   localparam int Div45Mul   = 23302;
   localparam int Div45Shift = 20;

   localparam logic [15:0] PhaseTicksRst = 16'd10;
   localparam logic [11:0] PhaseCountMax = 12'd4092;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_MOVE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      DIR_CW  = 2'd0,
      DIR_CCW = 2'd1
   } dir_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_ARG = 2'd1,
      STATUS_BUSY    = 2'd2
   } status_type;

   // accepted input beat with the partial angle product attached
   typedef struct packed {
      cmd_type     command;
      logic [8:0]  angle;
      logic [1:0]  direction;
      logic [17:0] rem_prod;
   } item_type;

   typedef struct packed {
      logic [3:0] coils;
      logic       busy_res;
      status_type status;
      logic       move_done;
   } result_type;

   // active-low wave drive, one coil low
   function automatic logic [3:0] pattern_for(input logic [1:0] idx, input logic ccw);
      logic [3:0] low_bit;
      low_bit = ccw ? (4'b0001 << idx) : (4'b1000 >> idx);
      return ~low_bit;
   endfunction

endpackage

FILE: sv/stepper_angle_move_sequencer.sv
// top level of the stepper angle move sequencer
// instantiates stp_in_stage and stp_core; uses stp_pkg
//
// Wave-drive sequencer for a unipolar stepper. A request beat is either a time
// tick (req_tuser = 0) or a move start (req_tuser = 1) carrying an angle in
// degrees and a direction; a move runs floor(angle * STEPS_PER_REV / 360)
// rounded down to a multiple of four phases, each held for phase_ticks ticks
// (written through csr_wr_en / csr_wr_data, reset value 10, 0 acts as 1).
// Every request beat yields exactly one response beat with the active-low coil
// levels, the busy flag, the start status and, on rsp_tlast, the end of a move.
// One beat is accepted per clock cycle while the response side keeps taking beats;
// a response passes the input register, then the state update in stp_core into
// the result register, and both registers keep flowing while the response
// side stalls until they are full.
module stepper_angle_move_sequencer #(
   parameter int STEPS_PER_REV = stp_pkg::StepsPerRevDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,  // phase_ticks
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // angle[8:0], direction[10:9], zero [15:11]
   input  logic        req_tuser,    // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // coils[3:0], busy_res[4], status[6:5], zero [7]
   output logic        rsp_tlast     // move_done
);
   import stp_pkg::*;

   logic       item_valid;
   logic       item_ready;
   item_type   item;
   result_type rsp;

   stp_in_stage #(
      .STEPS_PER_REV (STEPS_PER_REV)
   ) u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   stp_core #(
      .STEPS_PER_REV (STEPS_PER_REV)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .item        (item),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.status, rsp.busy_res, rsp.coils};
   assign rsp_tlast = rsp.move_done;

endmodule

FILE: sv/stp_in_stage.sv
// input register of the stepper sequencer: captures a request beat and
// starts the angle-to-steps conversion; uses stp_pkg
module stp_in_stage #(
   parameter int STEPS_PER_REV = stp_pkg::StepsPerRevDef
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,
   input  logic              req_tuser,
   output logic              item_valid,
   input  logic              item_ready,
   output stp_pkg::item_type item
);
   import stp_pkg::*;

   localparam int RevRem = STEPS_PER_REV % DegPerRev;

   logic     item_valid_ff, item_valid_in;
   item_type item_ff, item_in;
   logic     req_fire;

   assign req_tready = !item_valid_ff || item_ready;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      item_in           = item_ff;
      item_valid_in     = item_valid_ff;
      if (req_fire) begin
         item_in.command   = cmd_type'(req_tuser);
         item_in.angle     = req_tdata[8:0];
         item_in.direction = req_tdata[10:9];
         // remainder part of angle * steps_per_rev, divided by 360 in the core
         item_in.rem_prod  = 18'(req_tdata[8:0]) * 18'(RevRem);
         item_valid_in     = 1'b1;
      end else if (item_ready) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

FILE: sv/stp_core.sv
// move sequencer state, phase timing and result register of the stepper
// sequencer; uses stp_pkg
module stp_core #(
   parameter int STEPS_PER_REV = stp_pkg::StepsPerRevDef
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data,
   input  logic                item_valid,
   output logic                item_ready,
   input  stp_pkg::item_type   item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output stp_pkg::result_type rsp
);
   import stp_pkg::*;

   localparam int RevWhole = STEPS_PER_REV / DegPerRev;

   logic [15:0] phase_ticks_ff, phase_ticks_in;
   logic [3:0]  coil_pattern_ff, coil_pattern_in;
   logic [1:0]  phase_index_ff, phase_index_in;
   logic [11:0] phases_left_ff, phases_left_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic        moving_ff, moving_in;
   logic        rotate_ccw_ff, rotate_ccw_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;

   logic        fire;
   logic [29:0] div_prod;
   logic [12:0] whole_steps;
   logic [13:0] steps;
   logic [11:0] phase_count;
   logic        args_bad;
   logic        new_ccw;
   logic [16:0] limit;
   logic [16:0] tick_next;
   logic [11:0] phases_dec;
   logic [1:0]  index_next;
   status_type  status;
   logic        done;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign fire       = item_valid && item_ready;

   // steps = angle * whole + floor(angle * rem / 360), 360 = 8 * 45
   assign div_prod    = 30'(item.rem_prod[17:3]) * 30'(Div45Mul);
   assign whole_steps = 13'(item.angle) * 13'(RevWhole);
   assign steps       = 14'(whole_steps) + 14'(div_prod[29:Div45Shift]);

   always_comb begin
      if (steps > 14'd4095) begin
         phase_count = PhaseCountMax;
      end else begin
         phase_count = {steps[11:2], 2'b00};
      end
   end

   assign args_bad   = (item.direction != DIR_CW && item.direction != DIR_CCW)
                       || (item.angle > 9'(AngleMax));
   assign new_ccw    = (item.direction == DIR_CCW);
   assign limit      = (phase_ticks_ff == 16'd0) ? 17'd1 : 17'(phase_ticks_ff);
   assign tick_next  = 17'(tick_count_ff) + 17'd1;
   assign phases_dec = phases_left_ff - 12'd1;
   assign index_next = phase_index_ff + 2'd1;

   always_comb begin
      coil_pattern_in = coil_pattern_ff;
      phase_index_in  = phase_index_ff;
      phases_left_in  = phases_left_ff;
      tick_count_in   = tick_count_ff;
      moving_in       = moving_ff;
      rotate_ccw_in   = rotate_ccw_ff;
      status          = STATUS_OK;
      done            = 1'b0;
      if (fire) begin
         if (item.command == CMD_MOVE) begin
            if (args_bad) begin
               status = STATUS_BAD_ARG;
            end else if (moving_ff) begin
               status = STATUS_BUSY;
            end else if (phase_count != 12'd0) begin
               rotate_ccw_in   = new_ccw;
               phase_index_in  = 2'd0;
               phases_left_in  = phase_count;
               tick_count_in   = 16'd0;
               moving_in       = 1'b1;
               coil_pattern_in = pattern_for(2'd0, new_ccw);
            end
         end else if (moving_ff) begin
            if (tick_next >= limit) begin
               tick_count_in  = 16'd0;
               phases_left_in = phases_dec;
               if (phases_dec == 12'd0) begin
                  moving_in = 1'b0;
                  done      = 1'b1;
               end else begin
                  phase_index_in  = index_next;
                  coil_pattern_in = pattern_for(index_next, rotate_ccw_ff);
               end
            end else begin
               tick_count_in = tick_next[15:0];
            end
         end
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_in.coils     = coil_pattern_in;
         rsp_in.busy_res  = moving_in;
         rsp_in.status    = status;
         rsp_in.move_done = done;
         rsp_valid_in     = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign phase_ticks_in = csr_wr_en ? csr_wr_data : phase_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff  <= PhaseTicksRst;
         coil_pattern_ff <= 4'd0;
         phase_index_ff  <= 2'd0;
         phases_left_ff  <= 12'd0;
         tick_count_ff   <= 16'd0;
         moving_ff       <= 1'b0;
         rotate_ccw_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ticks_ff  <= phase_ticks_in;
         coil_pattern_ff <= coil_pattern_in;
         phase_index_ff  <= phase_index_in;
         phases_left_ff  <= phases_left_in;
         tick_count_ff   <= tick_count_in;
         moving_ff       <= moving_in;
         rotate_ccw_ff   <= rotate_ccw_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: dv/stp_move_checker.sv
// checker for the stepper angle move sequencer: watches the csr, request and response
// channels, predicts the coil drive and status of every request and compares them
// depends on stp_pkg for the command, direction, status and result types
module stp_move_checker #(
   parameter int STEPS_PER_REV = stp_pkg::StepsPerRevDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,    // angle[8:0], direction[10:9], zero [15:11]
   input  logic        req_tuser,    // command
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,    // coils[3:0], busy_res[4], status[6:5], zero [7]
   input  logic        rsp_tlast,    // move_done
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import stp_pkg::*;

   localparam int ReportMax = 10;

   // motor state as the block should hold it
   logic [15:0] hold_ticks;
   logic [3:0]  coil_lv;
   logic [1:0]  phase_idx;
   logic [11:0] phases_rem;
   logic [15:0] tick_cnt;
   logic        moving;
   logic        ccw;

   result_type expected_drive_q[$];

   // one coil pulled low: pin 3 first going clockwise, pin 0 first going anticlockwise
   function automatic logic [3:0] coil_drive(input logic [1:0] idx, input logic rev);
      logic [1:0] low_pin;
      low_pin = rev ? idx : 2'd3 - idx;
      coil_drive = 4'hF;
      coil_drive[low_pin] = 1'b0;
   endfunction

   function automatic result_type advance_motor(input cmd_type cmd, input logic [8:0] angle,
                                                input logic [1:0] dir);
      result_type res;
      int         steps;
      int         phases;
      logic [16:0] limit;
      logic [16:0] nxt;
      res.status    = STATUS_OK;
      res.move_done = 1'b0;
      if (cmd == CMD_MOVE) begin
         if (dir > DIR_CCW || angle > AngleMax) begin
            res.status = STATUS_BAD_ARG;
         end else if (moving) begin
            res.status = STATUS_BUSY;
         end else begin
            steps  = int'(angle) * STEPS_PER_REV / DegPerRev;
            phases = (steps / 4) * 4;
            if (phases > 4095) phases = int'(PhaseCountMax);
            // a zero-phase move is accepted but leaves everything as it was
            if (phases != 0) begin
               ccw        = (dir == DIR_CCW);
               phase_idx  = 2'd0;
               phases_rem = 12'(phases);
               tick_cnt   = 16'd0;
               moving     = 1'b1;
               coil_lv    = coil_drive(2'd0, ccw);
            end
         end
      end else if (moving) begin
         limit = (hold_ticks == 16'd0) ? 17'd1 : {1'b0, hold_ticks};
         nxt   = {1'b0, tick_cnt} + 17'd1;
         if (nxt >= limit) begin
            tick_cnt   = 16'd0;
            phases_rem = phases_rem - 12'd1;
            if (phases_rem == 12'd0) begin
               moving        = 1'b0;
               res.move_done = 1'b1;
            end else begin
               phase_idx = phase_idx + 2'd1;
               coil_lv   = coil_drive(phase_idx, ccw);
            end
         end else begin
            tick_cnt = nxt[15:0];
         end
      end
      res.coils    = coil_lv;
      res.busy_res = moving;
      return res;
   endfunction

   task automatic note_mismatch(input bit has_want, input result_type want,
                                input result_type got);
      fail_count++;
      if (fail_count <= ReportMax) begin
         if (has_want)
            $display("%0t rsp mismatch: expected coils=%h busy=%b status=%0d done=%b, got coils=%h busy=%b status=%0d done=%b",
                     $realtime, want.coils, want.busy_res, want.status, want.move_done,
                     got.coils, got.busy_res, got.status, got.move_done);
         else
            $display("%0t rsp beat with nothing expected: coils=%h busy=%b status=%0d done=%b",
                     $realtime, got.coils, got.busy_res, got.status, got.move_done);
      end
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         hold_ticks = PhaseTicksRst;
         coil_lv    = 4'd0;
         phase_idx  = 2'd0;
         phases_rem = 12'd0;
         tick_cnt   = 16'd0;
         moving     = 1'b0;
         ccw        = 1'b0;
         fail_count = 0;
         expected_drive_q.delete();
      end else begin
         if (csr_wr_en) hold_ticks = csr_wr_data;
         // compare before predicting: a response never belongs to a beat of the same edge
         if (rsp_tvalid && rsp_tready) begin
            got.coils     = rsp_tdata[3:0];
            got.busy_res  = rsp_tdata[4];
            got.status    = status_type'(rsp_tdata[6:5]);
            got.move_done = rsp_tlast;
            if (expected_drive_q.size() == 0) begin
               note_mismatch(1'b0, got, got);
            end else begin
               want = expected_drive_q.pop_front();
               if (got.coils !== want.coils || got.busy_res !== want.busy_res ||
                   got.status !== want.status || got.move_done !== want.move_done)
                  note_mismatch(1'b1, want, got);
            end
         end
         if (req_tvalid && req_tready)
            expected_drive_q.push_back(advance_motor(cmd_type'(req_tuser), req_tdata[8:0],
                                                     req_tdata[10:9]));
      end
      pending_count = expected_drive_q.size();
   end

endmodule

FILE: dv/stepper_angle_move_sequencer_tb.sv
// testbench top of the stepper angle move sequencer: clock, reset, request and
// response pacing, phase_ticks writes and the verdict
// depends on stp_pkg, stepper_angle_move_sequencer and stp_move_checker
module stepper_angle_move_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import stp_pkg::*;

   localparam int CycleLimit  = 1_000_000;
   localparam int RandomBeats = 1240;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // angle[8:0], direction[10:9], zero [15:11]
   logic        req_tuser;    // command
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // coils[3:0], busy_res[4], status[6:5], zero [7]
   logic        rsp_tlast;    // move_done

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int beats_sent  = 0;
   bit req_quiet   = 1'b0;
   bit rsp_quiet   = 1'b0;

   stepper_angle_move_sequencer u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   stp_move_checker u_chk (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // response side: a fresh random stall, possibly none, before every beat
   initial begin : rsp_side
      int stall;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         stall = rsp_quiet ? 0 : $urandom_range(0, 19);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // returns right after the edge that took the beat; valid stays up until the next call
   task automatic send_beat(input cmd_type cmd, input logic [8:0] angle, input logic [1:0] dir);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'd0, dir, angle};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_beat(CMD_TICK, 9'($urandom), 2'($urandom));
   endtask

   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic set_phase_ticks(input logic [15:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_random(input int beats, input int hold);
      int stop_at;
      int pick;
      int ang;
      int span;
      stop_at = beats_sent + beats;
      while (beats_sent < stop_at) begin
         if ($urandom_range(0, 19) == 0) begin
            req_quiet = ($urandom_range(0, 2) == 0);
            rsp_quiet = ($urandom_range(0, 2) == 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // well-formed move followed by roughly enough ticks to finish it
            ang = ($urandom_range(0, 9) == 0) ? $urandom_range(0, AngleMax)
                                               : $urandom_range(0, 24);
            send_beat(CMD_MOVE, 9'(ang), 2'($urandom_range(0, 1)));
            span = (ang * StepsPerRevDef / DegPerRev) * (hold == 0 ? 1 : hold);
            span = $urandom_range(span / 2, span + 6);
            if (span > stop_at - beats_sent) span = stop_at - beats_sent;
            send_ticks(span);
         end else if (pick < 85) begin
            if ($urandom_range(0, 1))
               send_beat(CMD_MOVE, 9'($urandom_range(AngleMax + 1, 511)), 2'($urandom));
            else
               send_beat(CMD_MOVE, 9'($urandom), 2'($urandom_range(2, 3)));
         end else if (pick < 92) begin
            send_beat(CMD_MOVE, 9'($urandom_range(0, AngleMax)), 2'($urandom_range(0, 1)));
         end else begin
            send_ticks($urandom_range(1, 12));
         end
      end
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = 16'd0;
      req_tvalid  = 1'b0;
      req_tdata   = 16'd0;
      req_tuser   = CMD_TICK;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset value of phase_ticks, argument checks and busy rejection
      send_beat(CMD_TICK, 9'd511, 2'd3);
      send_beat(CMD_MOVE, 9'd0, DIR_CW);
      send_beat(CMD_MOVE, 9'd361, DIR_CW);
      send_beat(CMD_MOVE, 9'd511, 2'd3);
      send_beat(CMD_MOVE, 9'd10, 2'd2);
      send_beat(CMD_MOVE, 9'd360, 2'd3);
      send_beat(CMD_MOVE, 9'd1, DIR_CW);
      send_beat(CMD_MOVE, 9'd1, DIR_CCW);
      // bad argument wins over busy
      send_beat(CMD_MOVE, 9'd400, DIR_CCW);
      send_beat(CMD_MOVE, 9'd360, DIR_CW);
      send_ticks(10);
      set_phase_ticks(16'd1);
      send_ticks(3);
      send_beat(CMD_TICK, 9'd0, 2'd0);

      // eighth of a turn anticlockwise, zero acting as one tick per phase
      req_quiet = 1'b1;
      rsp_quiet = 1'b1;
      set_phase_ticks(16'd0);
      send_beat(CMD_MOVE, 9'd45, DIR_CCW);
      send_ticks(256);
      send_beat(CMD_TICK, 9'd255, 2'd1);

      // widest hold; the move runs on under the next setting
      set_phase_ticks(16'hFFFF);
      send_beat(CMD_MOVE, 9'd1, DIR_CW);
      send_ticks(20);
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;

      set_phase_ticks(16'd2);
      run_random(RandomBeats / 4, 2);
      set_phase_ticks(16'd1);
      run_random(RandomBeats / 4, 1);
      set_phase_ticks(16'd0);
      run_random(RandomBeats / 4, 0);
      set_phase_ticks(16'd3);
      run_random(RandomBeats / 4, 3);

      drain();
      repeat (4) @(negedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
